// File: rtl/hsp_pkg.sv
package hsp_pkg;

   localparam int unsigned FIELD_COUNT = 7;

   // Parse phases
   localparam logic [3:0] PH_FIRST  = 4'd0;
   localparam logic [3:0] PH_STYPE  = 4'd1;
   localparam logic [3:0] PH_PPS    = 4'd2;
   localparam logic [3:0] PH_FRAME  = 4'd3;
   localparam logic [3:0] PH_FIELD  = 4'd4;
   localparam logic [3:0] PH_BOTTOM = 4'd5;
   localparam logic [3:0] PH_IDR    = 4'd6;
   localparam logic [3:0] PH_POC    = 4'd7;
   localparam logic [3:0] PH_DELTA  = 4'd8;
   localparam logic [3:0] PH_DONE   = 4'd9;
   localparam logic [3:0] PH_STOP   = 4'd10;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_FRAME_LEN = 3'd2;
   localparam logic [2:0] ST_POC_LEN   = 3'd3;
   localparam logic [2:0] ST_PREFIX    = 3'd4;
   localparam logic [2:0] ST_FRAME_NUM = 3'd5;
   localparam logic [2:0] ST_FIELD     = 3'd6;
   localparam logic [2:0] ST_BOTTOM    = 3'd7;

   // Configuration register indexes
   localparam logic [2:0] REG_FRAME_LEN = 3'd0;
   localparam logic [2:0] REG_POC_LEN   = 3'd1;
   localparam logic [2:0] REG_POC_TYPE  = 3'd2;
   localparam logic [2:0] REG_MBS_ONLY  = 3'd3;
   localparam logic [2:0] REG_IDR       = 3'd4;
   localparam logic [2:0] REG_BOTTOM    = 3'd5;

   // Field store slots
   localparam int unsigned FS_FIRST = 0;
   localparam int unsigned FS_STYPE = 1;
   localparam int unsigned FS_PPS   = 2;
   localparam int unsigned FS_FRAME = 3;
   localparam int unsigned FS_IDR   = 4;
   localparam int unsigned FS_POC   = 5;
   localparam int unsigned FS_DELTA = 6;

   // Flag store bits
   localparam int unsigned FL_FIELD_P  = 0;
   localparam int unsigned FL_BOTTOM_P = 1;
   localparam int unsigned FL_IDR_P    = 2;
   localparam int unsigned FL_POC_P    = 3;
   localparam int unsigned FL_DELTA_P  = 4;
   localparam int unsigned FL_FIELD_V  = 5;
   localparam int unsigned FL_BOTTOM_V = 6;

   localparam logic [3:0] MAX_LEN_MINUS4 = 4'd12;
   localparam logic [5:0] MAX_ZEROS      = 6'd31;

   typedef struct packed {
      logic [3:0] frame_len_m4;
      logic [3:0] poc_len_m4;
      logic [1:0] poc_type;
      logic       frame_mbs_only;
      logic       idr_slice;
      logic       bottom_poc_present;
   } hsp_cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       feed;
      logic       last;
      logic       short_unit;
   } hsp_item_type;

   typedef struct packed {
      logic [3:0]                        phase;
      logic [5:0]                        zeros;
      logic [32:0]                       accum;
      logic [5:0]                        left;
      logic [FIELD_COUNT-1:0][31:0]      fields;
      logic [6:0]                        flags;
      logic [2:0]                        err;
   } hsp_parse_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] first_mb;
      logic [31:0] slice_type_code;
      logic [31:0] pps_id;
      logic [15:0] frame_number;
      logic [4:0]  present_mask;
      logic [1:0]  field_bits;
      logic [31:0] idr_id;
      logic [15:0] poc_lsb;
      logic [31:0] poc_bottom_delta;
   } hsp_result_type;

endpackage

// File: rtl/h264_slice_header_parser.sv
// Slice header parser: takes the raw bytes of one slice NAL unit (header byte
// first, tlast on the final byte) at one byte per clock, and on the final byte
// delivers one result transaction with the status and the decoded header fields.
// The byte rate is set by the back-end parser, which walks the eight bits of a
// byte through its bit decoder combinationally; a four-entry queue separates it
// from the emulation-prevention front end. A result is presented from the result
// register once its final byte leaves the queue, when no bytes wait ahead of it
// and the result register is free. A final byte waits at the queue head while an
// earlier result is still held off by rsp_tready, and once the queue fills
// req_tready drops. Configuration must be written while idle.
module h264_slice_header_parser
   import hsp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] payload_byte
   input  logic         req_tlast,    // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] status, [34:3] first_mb, [66:35] slice_type_code, [69:67] slice_class,
   // [70] all_slices_same, [102:71] pps_id, [118:103] frame_number,
   // [123:119] present_mask, [125:124] field_bits, [157:126] idr_id,
   // [173:158] poc_lsb, [205:174] poc_bottom_delta, [207:206] zero
   output logic [207:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [3:0]   csr_data
);

   hsp_cfg_type    cfg_ff;
   hsp_item_type   push_item, head;
   hsp_result_type res;
   logic           push, full, not_empty, pop;
   logic [6:0]     nib_sum;
   logic [4:0]     fold;
   logic [2:0]     kind;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_len_m4       <= 4'd0;
         cfg_ff.poc_len_m4         <= 4'd0;
         cfg_ff.poc_type           <= 2'd2;
         cfg_ff.frame_mbs_only     <= 1'b1;
         cfg_ff.idr_slice          <= 1'b0;
         cfg_ff.bottom_poc_present <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_LEN: cfg_ff.frame_len_m4       <= csr_data;
            REG_POC_LEN:   cfg_ff.poc_len_m4         <= csr_data;
            REG_POC_TYPE:  cfg_ff.poc_type           <= csr_data[1:0];
            REG_MBS_ONLY:  cfg_ff.frame_mbs_only     <= csr_data[0];
            REG_IDR:       cfg_ff.idr_slice          <= csr_data[0];
            REG_BOTTOM:    cfg_ff.bottom_poc_present <= csr_data[0];
            default: ;
         endcase
      end
   end

   hsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .in_last   (req_tlast),
      .queue_full(full),
      .in_ready  (req_tready),
      .push      (push),
      .push_item (push_item)
   );

   hsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .full     (full),
      .not_empty(not_empty),
      .head     (head)
   );

   hsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item_valid(not_empty),
      .item      (head),
      .out_ready (rsp_tready),
      .item_pop  (pop),
      .out_valid (rsp_tvalid),
      .out_result(res)
   );

   // Since 16 is 1 modulo 5, the nibble sum keeps the residue; fold once more.
   always_comb begin
      nib_sum = '0;
      for (int i = 0; i < 8; i++) begin
         nib_sum = nib_sum + {3'b000, res.slice_type_code[4*i +: 4]};
      end
      fold = {2'b00, nib_sum[6:4]} + {1'b0, nib_sum[3:0]};
      if (fold >= 5'd20) kind = 3'(fold - 5'd20);
      else if (fold >= 5'd15) kind = 3'(fold - 5'd15);
      else if (fold >= 5'd10) kind = 3'(fold - 5'd10);
      else if (fold >= 5'd5) kind = 3'(fold - 5'd5);
      else kind = fold[2:0];
   end

   assign rsp_tdata = {2'b00, res.poc_bottom_delta, res.poc_lsb, res.idr_id,
                       res.field_bits, res.present_mask, res.frame_number,
                       res.pps_id, (res.slice_type_code >= 32'd5), kind,
                       res.slice_type_code, res.first_mb, res.status};

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[69:67] < 3'd5)
      else $error("slice kind out of range");

endmodule

// File: rtl/hsp_front.sv
module hsp_front
   import hsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [7:0]   in_data,
   input  logic         in_last,
   input  logic         queue_full,
   output logic         in_ready,
   output logic         push,
   output hsp_item_type push_item
);

   logic [1:0] zero_run_ff, zero_run_in;
   logic [1:0] raw_cnt_ff, raw_cnt_in;
   logic       drop;

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   // An emulation-prevention byte is a 0x03 right after two zero bytes.
   assign drop = (zero_run_ff == 2'd2) && (in_data == 8'd3);

   always_comb begin
      push_item.data       = in_data;
      push_item.feed       = !drop && (raw_cnt_ff != 2'd0);
      push_item.last       = in_last;
      push_item.short_unit = (raw_cnt_ff == 2'd0);
      zero_run_in = zero_run_ff;
      raw_cnt_in  = raw_cnt_ff;
      if (push) begin
         if (drop) begin
            zero_run_in = 2'd0;
         end else if (in_data == 8'd0) begin
            zero_run_in = (zero_run_ff == 2'd2) ? 2'd2 : zero_run_ff + 2'd1;
         end else begin
            zero_run_in = 2'd0;
         end
         raw_cnt_in = (raw_cnt_ff == 2'd2) ? 2'd2 : raw_cnt_ff + 2'd1;
         if (in_last) begin
            zero_run_in = 2'd0;
            raw_cnt_in  = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff <= 2'd0;
         raw_cnt_ff  <= 2'd0;
      end else begin
         zero_run_ff <= zero_run_in;
         raw_cnt_ff  <= raw_cnt_in;
      end
   end

endmodule

// File: rtl/hsp_queue.sv
module hsp_queue
   import hsp_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hsp_item_type push_item,
   input  logic         pop,
   output logic         full,
   output logic         not_empty,
   output hsp_item_type head
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   hsp_item_type [DEPTH-1:0] slot_ff;
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

// File: rtl/hsp_back.sv
module hsp_back
   import hsp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  hsp_cfg_type    cfg,
   input  logic           item_valid,
   input  hsp_item_type   item,
   input  logic           out_ready,
   output logic           item_pop,
   output logic           out_valid,
   output hsp_result_type out_result
);

   hsp_parse_type  st_ff, st_in, st_next;
   logic           valid_ff, valid_in;
   hsp_result_type res_ff, res_in;
   logic [2:0]     status;

   function automatic logic [3:0] after_idr(hsp_cfg_type c);
      return (c.poc_type == 2'd0) ? PH_POC : PH_DONE;
   endfunction

   function automatic logic [3:0] after_field(hsp_cfg_type c);
      return c.idr_slice ? PH_IDR : after_idr(c);
   endfunction

   function automatic logic [2:0] phase_status(logic [3:0] p);
      logic [2:0] r;
      r = ST_OK;
      if (p <= PH_PPS) r = ST_PREFIX;
      else if (p == PH_FRAME) r = ST_FRAME_NUM;
      else if (p == PH_FIELD) r = ST_FIELD;
      else if (p == PH_BOTTOM) r = ST_BOTTOM;
      return r;
   endfunction

   function automatic hsp_parse_type begin_phase(hsp_parse_type s, logic [3:0] p,
                                                 hsp_cfg_type c);
      hsp_parse_type r;
      r       = s;
      r.phase = p;
      r.zeros = '0;
      r.accum = '0;
      r.left  = '0;
      if (p == PH_FRAME) r.left = {2'b00, c.frame_len_m4} + 6'd4;
      if (p == PH_POC) r.left = {2'b00, c.poc_len_m4} + 6'd4;
      return r;
   endfunction

   function automatic hsp_parse_type finish(hsp_parse_type s, logic [32:0] v,
                                            hsp_cfg_type c);
      hsp_parse_type r;
      logic [32:0]   half;
      logic [32:0]   sv;
      r    = s;
      half = v >> 1;
      sv   = v[0] ? half + 33'd1 : 33'd0 - half;
      unique case (s.phase)
         PH_FIRST: begin
            r.fields[FS_FIRST] = v[31:0];
            r = begin_phase(r, PH_STYPE, c);
         end
         PH_STYPE: begin
            r.fields[FS_STYPE] = v[31:0];
            r = begin_phase(r, PH_PPS, c);
         end
         PH_PPS: begin
            r.fields[FS_PPS] = v[31:0];
            r = begin_phase(r, PH_FRAME, c);
         end
         PH_FRAME: begin
            r.fields[FS_FRAME] = v[31:0];
            r = begin_phase(r, c.frame_mbs_only ? after_field(c) : PH_FIELD, c);
         end
         PH_FIELD: begin
            r.flags[FL_FIELD_P] = 1'b1;
            r.flags[FL_FIELD_V] = v[0];
            r = begin_phase(r, v[0] ? PH_BOTTOM : after_field(c), c);
         end
         PH_BOTTOM: begin
            r.flags[FL_BOTTOM_P] = 1'b1;
            r.flags[FL_BOTTOM_V] = v[0];
            r = begin_phase(r, after_field(c), c);
         end
         PH_IDR: begin
            r.fields[FS_IDR]   = v[31:0];
            r.flags[FL_IDR_P]  = 1'b1;
            r = begin_phase(r, after_idr(c), c);
         end
         PH_POC: begin
            r.fields[FS_POC]  = v[31:0];
            r.flags[FL_POC_P] = 1'b1;
            r = begin_phase(r, (c.bottom_poc_present && !s.flags[FL_FIELD_V]) ?
                            PH_DELTA : PH_DONE, c);
         end
         PH_DELTA: begin
            r.fields[FS_DELTA]  = sv[31:0];
            r.flags[FL_DELTA_P] = 1'b1;
            r = begin_phase(r, PH_DONE, c);
         end
         default: r = s;
      endcase
      return r;
   endfunction

   // One bitstream bit against the parse state.
   function automatic hsp_parse_type feed_bit(hsp_parse_type s, logic b, hsp_cfg_type c);
      hsp_parse_type r;
      logic [32:0]   shifted;
      r       = s;
      shifted = {s.accum[31:0], b};
      unique case (s.phase)
         PH_FIRST, PH_STYPE, PH_PPS, PH_IDR, PH_DELTA: begin
            if (s.left == 6'd0) begin
               if (!b) begin
                  r.zeros = s.zeros + 6'd1;
                  if (s.zeros == MAX_ZEROS) begin
                     r.err   = phase_status(s.phase);
                     r.phase = PH_STOP;
                  end
               end else if (s.zeros == 6'd0) begin
                  r = finish(s, 33'd0, c);
               end else begin
                  r.left  = s.zeros;
                  r.accum = 33'd1;
               end
            end else begin
               r.accum = shifted;
               r.left  = s.left - 6'd1;
               if (s.left == 6'd1) r = finish(r, shifted - 33'd1, c);
            end
         end
         PH_FRAME, PH_POC: begin
            if (s.left != 6'd0) begin
               r.accum = shifted;
               r.left  = s.left - 6'd1;
            end
            if (r.left == 6'd0) r = finish(r, r.accum, c);
         end
         PH_FIELD, PH_BOTTOM: begin
            r = finish(s, {32'd0, b}, c);
         end
         default: r = s;
      endcase
      return r;
   endfunction

   // A final byte can only be taken once the result register is free.
   assign item_pop   = item_valid && (!item.last || !valid_ff || out_ready);
   assign out_valid  = valid_ff;
   assign out_result = res_ff;

   always_comb begin
      st_next = st_ff;
      if (item.feed) begin
         for (int i = 7; i >= 0; i--) begin
            st_next = feed_bit(st_next, item.data[i], cfg);
         end
      end

      if (item.short_unit) status = ST_SHORT;
      else if (cfg.frame_len_m4 > MAX_LEN_MINUS4) status = ST_FRAME_LEN;
      else if (cfg.poc_len_m4 > MAX_LEN_MINUS4) status = ST_POC_LEN;
      else if (st_next.phase == PH_STOP) status = st_next.err;
      else if (st_next.phase < PH_DONE) status = phase_status(st_next.phase);
      else status = ST_OK;

      res_in = '0;
      res_in.status = status;
      if (status == ST_OK) begin
         res_in.first_mb         = st_next.fields[FS_FIRST];
         res_in.slice_type_code  = st_next.fields[FS_STYPE];
         res_in.pps_id           = st_next.fields[FS_PPS];
         res_in.frame_number     = st_next.fields[FS_FRAME][15:0];
         res_in.present_mask     = st_next.flags[4:0];
         res_in.field_bits       = st_next.flags[6:5];
         res_in.idr_id           = st_next.fields[FS_IDR];
         res_in.poc_lsb          = st_next.fields[FS_POC][15:0];
         res_in.poc_bottom_delta = st_next.fields[FS_DELTA];
      end

      st_in    = st_ff;
      valid_in = valid_ff && !out_ready;
      if (item_pop) begin
         st_in = item.last ? '0 : st_next;
         if (item.last) valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && item.last) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
      end
   end

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (res_ff.status != ST_OK) |-> (res_ff.first_mb == 32'd0) &&
      (res_ff.present_mask == 5'd0))
      else $error("error result carries field values");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.phase <= PH_STOP)
      else $error("parse phase out of range");
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      item_pop && item.last |=> (st_ff.phase == PH_FIRST) && valid_ff)
      else $error("unit end did not restart parse");

endmodule
